>>> sv/filled_ellipse_span_generator_unit_macros.svh
// Assertion macros for the ellipse span generator.
`ifndef FILLED_ELLIPSE_SPAN_GENERATOR_UNIT_MACROS_SVH
`define FILLED_ELLIPSE_SPAN_GENERATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FESG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FESG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FESG_ASSERT_RST(lbl, prop, msg)
`define FESG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> sv/fesg_pkg.sv
package fesg_pkg;

  localparam int unsigned COORD_W       = 16;
  localparam int unsigned SIZE_W        = 10;
  localparam int unsigned SQ_W          = 2 * SIZE_W;
  localparam int unsigned ACC_W         = 40;
  localparam int unsigned MAX_MINOR_DEF = 63;
  localparam int unsigned MAX_MAJOR_DEF = 1023;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0]         dim_t;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    coord_t lo_base;
    coord_t hi_base;
    coord_t maj_start;
    coord_t maj_end;
    logic   horiz;
    dim_t   minor;
    dim_t   major;
    logic   refused;
  } job_t;

endpackage

>>> sv/fesg_front.sv
module fesg_front #(
  parameter int unsigned MAX_MINOR = fesg_pkg::MAX_MINOR_DEF,
  parameter int unsigned MAX_MAJOR = fesg_pkg::MAX_MAJOR_DEF
) (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fesg_pkg::coord_t origin_x_i,
  input  fesg_pkg::coord_t origin_y_i,
  input  fesg_pkg::dim_t   box_width_i,
  input  fesg_pkg::dim_t   box_height_i,
  input  logic            full_i,
  output logic            push_o,
  output fesg_pkg::job_t  job_o
);
  import fesg_pkg::*;

  logic   horiz;
  dim_t   minor;
  dim_t   major;
  dim_t   minor_m1;
  coord_t min_org;
  coord_t maj_org;
  logic   refused;
  logic   empty_req;

  always_comb begin
    horiz    = box_width_i > box_height_i;
    minor    = horiz ? box_height_i : box_width_i;
    major    = horiz ? box_width_i : box_height_i;
    minor_m1 = minor - 1'b1;
    min_org  = horiz ? origin_y_i : origin_x_i;
    maj_org  = horiz ? origin_x_i : origin_y_i;
    refused  = (32'(minor) > 32'(MAX_MINOR)) || (32'(major) > 32'(MAX_MAJOR));
    // A request with no extent produces nothing and is dropped here.
    empty_req = !refused && (minor == '0);

    job_o.lo_base   = min_org + {{(COORD_W-SIZE_W+1){1'b0}}, minor_m1[SIZE_W-1:1]};
    job_o.hi_base   = min_org + {{(COORD_W-SIZE_W+1){1'b0}}, minor[SIZE_W-1:1]};
    job_o.maj_start = maj_org;
    job_o.maj_end   = maj_org + {{(COORD_W-SIZE_W){1'b0}}, major};
    job_o.horiz     = horiz;
    job_o.minor     = minor;
    job_o.major     = major;
    job_o.refused   = refused;
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && !empty_req;

endmodule

>>> sv/fesg_queue.sv
module fesg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fesg_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output fesg_pkg::job_t job_o
);
  import fesg_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign job_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> sv/fesg_back.sv
module fesg_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  fesg_pkg::job_t   job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fesg_pkg::coord_t x_start_o,
  output fesg_pkg::coord_t y_start_o,
  output fesg_pkg::coord_t x_end_o,
  output fesg_pkg::coord_t y_end_o,
  output logic             last_span_o,
  output logic             too_large_o
);
  import fesg_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSetup1 = 3'd1;
  localparam logic [2:0] StSetup2 = 3'd2;
  localparam logic [2:0] StInset  = 3'd3;
  localparam logic [2:0] StEmit0  = 3'd4;
  localparam logic [2:0] StEmit1  = 3'd5;
  localparam logic [2:0] StError  = 3'd6;

  localparam int unsigned PROD_W = SQ_W + SIZE_W;

  logic [2:0]              state_q, state_d;
  job_t                    job_q;
  logic [SQ_W-1:0]         minor2_q;
  logic [SQ_W-1:0]         major2_q;
  logic signed [ACC_W-1:0] cl_q;
  logic signed [ACC_W-1:0] cr_q;
  logic signed [ACC_W-1:0] incl_q;
  logic signed [ACC_W-1:0] crinc_q;
  dim_t                    d_q;
  dim_t                    i_q;
  logic                    out_valid_q, out_valid_d;
  coord_t                  xs_q, ys_q, xe_q, ye_q;
  logic                    last_q, err_q;

  logic                    can_load;
  logic                    load;
  dim_t                    major_m1;
  dim_t                    minor_m1;
  logic [PROD_W-1:0]       prod;
  logic                    grow;
  logic                    last_step;
  coord_t                  d_ext, i_ext;
  coord_t                  near_pos, far_pos, low_line, high_line, line_pos;
  coord_t                  xs_d, ys_d, xe_d, ye_d;

  assign can_load  = !out_valid_q || out_ready_i;
  assign load      = can_load &&
                     (state_q == StEmit0 || state_q == StEmit1 || state_q == StError);
  assign pop_o     = (state_q == StIdle) && !empty_i;
  assign major_m1  = job_q.major - 1'b1;
  assign minor_m1  = job_q.minor - 1'b1;
  assign prod      = PROD_W'(minor2_q) * PROD_W'(major_m1);
  assign grow      = (cl_q < cr_q) && (d_q < job_q.major);
  assign last_step = i_q == {1'b0, minor_m1[SIZE_W-1:1]};

  always_comb begin
    d_ext     = {{(COORD_W-SIZE_W){1'b0}}, d_q};
    i_ext     = {{(COORD_W-SIZE_W){1'b0}}, i_q};
    near_pos  = job_q.maj_start + d_ext;
    far_pos   = job_q.maj_end - d_ext;
    low_line  = job_q.lo_base - i_ext;
    high_line = job_q.hi_base + i_ext;
    line_pos  = (state_q == StEmit0) ? low_line : high_line;
    if (state_q == StError) begin
      xs_d = '0;
      ys_d = '0;
      xe_d = '0;
      ye_d = '0;
    end else if (job_q.horiz) begin
      xs_d = near_pos;
      ys_d = line_pos;
      xe_d = far_pos;
      ye_d = line_pos;
    end else begin
      xs_d = line_pos;
      ys_d = near_pos;
      xe_d = line_pos;
      ye_d = far_pos;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          state_d = job_i.refused ? StError : StSetup1;
        end
      end
      StSetup1: state_d = StSetup2;
      StSetup2: state_d = StInset;
      StInset: begin
        if (!grow) begin
          state_d = StEmit0;
        end
      end
      StEmit0: begin
        if (can_load) begin
          state_d = StEmit1;
        end
      end
      StEmit1: begin
        if (can_load) begin
          state_d = last_step ? StIdle : StInset;
        end
      end
      StError: begin
        if (can_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    case (state_q)
      StSetup1: begin
        minor2_q <= SQ_W'(job_q.minor) * SQ_W'(job_q.minor);
        major2_q <= SQ_W'(job_q.major) * SQ_W'(job_q.major);
      end
      StSetup2: begin
        incl_q  <= ACC_W'(prod);
        crinc_q <= ACC_W'(major2_q);
        cl_q    <= '0;
        cr_q    <= '0;
        d_q     <= '0;
        i_q     <= '0;
      end
      StInset: begin
        if (grow) begin
          cl_q   <= cl_q + incl_q;
          incl_q <= incl_q - ACC_W'({minor2_q, 1'b0});
          d_q    <= d_q + 1'b1;
        end
      end
      StEmit1: begin
        if (can_load) begin
          cr_q    <= cr_q + crinc_q;
          crinc_q <= crinc_q + ACC_W'({major2_q, 1'b0});
          i_q     <= i_q + 1'b1;
        end
      end
      default: ;
    endcase
    if (load) begin
      xs_q   <= xs_d;
      ys_q   <= ys_d;
      xe_q   <= xe_d;
      ye_q   <= ye_d;
      err_q  <= state_q == StError;
      last_q <= (state_q == StError) || ((state_q == StEmit1) && last_step);
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_start_o   = xs_q;
  assign y_start_o   = ys_q;
  assign x_end_o     = xe_q;
  assign y_end_o     = ye_q;
  assign last_span_o = last_q;
  assign too_large_o = err_q;

endmodule

>>> sv/filled_ellipse_span_generator_unit.sv
// A request reaches the queue at acceptance. The back end pops it only from idle, squares
// the axes, clears its accumulators, runs the one-step-per-cycle inset loop, then registers a
// lower and an upper span per line pair, holding while the output is stalled; a refusal goes
// straight to a zeroed span marked last. The next request is popped once the back end is idle.
// Reset clears the queue, the sequencer and the output valid; payload registers keep data.
`include "filled_ellipse_span_generator_unit_macros.svh"

module filled_ellipse_span_generator_unit #(
  parameter int unsigned MAX_MINOR = fesg_pkg::MAX_MINOR_DEF,
  parameter int unsigned MAX_MAJOR = fesg_pkg::MAX_MAJOR_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fesg_pkg::coord_t origin_x_i,
  input  fesg_pkg::coord_t origin_y_i,
  input  fesg_pkg::dim_t   box_width_i,
  input  fesg_pkg::dim_t   box_height_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fesg_pkg::coord_t x_start_o,
  output fesg_pkg::coord_t y_start_o,
  output fesg_pkg::coord_t x_end_o,
  output fesg_pkg::coord_t y_end_o,
  output logic             last_span_o,
  output logic             too_large_o
);
  import fesg_pkg::*;

  job_t front_job;
  job_t queue_job;
  logic push;
  logic pop;
  logic full;
  logic empty;

  fesg_front #(
    .MAX_MINOR(MAX_MINOR),
    .MAX_MAJOR(MAX_MAJOR)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .box_width_i (box_width_i),
    .box_height_i(box_height_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (front_job)
  );

  fesg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .job_o  (queue_job)
  );

  fesg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .job_i      (queue_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .x_start_o  (x_start_o),
    .y_start_o  (y_start_o),
    .x_end_o    (x_end_o),
    .y_end_o    (y_end_o),
    .last_span_o(last_span_o),
    .too_large_o(too_large_o)
  );

  `FESG_ASSERT_RST(a_refusal_is_last, (out_valid_o && too_large_o) |-> last_span_o, "refusal not marked last")
  `FESG_ASSERT_RST(a_refusal_zero, (out_valid_o && too_large_o) |-> (x_start_o == '0 && y_start_o == '0 && x_end_o == '0 && y_end_o == '0), "refusal carries coordinates")
  `FESG_ASSERT_RST(a_span_axis, (out_valid_o && !too_large_o) |-> (y_start_o == y_end_o || x_start_o == x_end_o), "span is neither horizontal nor vertical")
  `FESG_ASSERT_ALWAYS(a_no_push_when_full, (push && full) |-> !in_ready_o, "request pushed into a full queue")

endmodule
